/* hdl/psqrt_pkg.sv */
// ----------------------------------------------------------------------------
// psqrt_pkg
// shared widths, limits and state codes of the perfect-square root block
// ----------------------------------------------------------------------------
package psqrt_pkg;

    // operand width, two's complement
    localparam int DATA_WIDTH  = 32;
    // stream data width, padded to whole bytes
    localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
    // newton step cap
    localparam int MAX_STEPS   = 2 * DATA_WIDTH + 8;
    localparam int STEP_W      = $clog2(MAX_STEPS);
    // divider bit counter, holds DATA_WIDTH itself
    localparam int BIT_CNT_W   = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_TEST_A,
        ST_DIV_B,
        ST_TEST_B,
        ST_DONE
    } state_t;

endpackage

/* hdl/perfect_square_root_newton_top.sv */
// ----------------------------------------------------------------------------
// perfect_square_root_newton_top
// exact integer square root by newton iteration on a bit-serial divider
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata: value (signed)
// m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata: root (signed)
//
// one transaction in gives one transaction out, in order
// values below two (negatives too) skip the divider: idle goes straight to done
// each newton step runs two restoring divisions, one quotient bit per cycle,
// and a transaction runs at most MAX_STEPS steps before it gives up with all ones
// rst_n clears the state machine and the output valid; a stalled output
// holds its result while the next value is already accepted
//
module perfect_square_root_newton_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // bits [DATA_WIDTH-1:0]: value, rest padding
    input  logic [psqrt_pkg::TDATA_WIDTH-1:0]  s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // bits [DATA_WIDTH-1:0]: root, rest zero
    output logic [psqrt_pkg::TDATA_WIDTH-1:0]  m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);

    localparam int DW = psqrt_pkg::DATA_WIDTH;

    // control state
    psqrt_pkg::state_t                state_reg, state_next;
    logic [psqrt_pkg::STEP_W-1:0]     steps_reg, steps_next;
    logic [psqrt_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                             out_valid_reg, out_valid_next;

    // datapath
    psqrt_pkg::word_t  n_reg, n_next;         // number under test
    psqrt_pkg::word_t  guess_reg, guess_next; // current guess, also the divisor
    psqrt_pkg::word_t  rem_reg, rem_next;     // partial remainder
    psqrt_pkg::word_t  quo_reg, quo_next;     // dividend bits out, quotient bits in
    psqrt_pkg::word_t  result_reg, result_next;
    psqrt_pkg::word_t  root_reg, root_next;

    // divider step and newton update
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              q_bit;
    logic [DW:0]       sum;
    psqrt_pkg::word_t  new_guess;
    psqrt_pkg::word_t  in_value;
    logic              echo;
    logic              ge_test;
    logic              exact;
    logic              out_take;

    assign in_value = s_axis_tdata[DW-1:0];
    // negatives and values 0, 1 pass straight through
    assign echo     = in_value[DW-1] || (in_value[DW-1:1] == '0);

    // restoring division: one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, guess_reg};
    assign q_bit = ~diff[DW];

    // guess * guess >= n, judged from quotient and remainder
    assign ge_test   = (guess_reg > quo_reg) || ((guess_reg == quo_reg) && (rem_reg == '0));
    assign exact     = (guess_reg == quo_reg) && (rem_reg == '0);
    assign sum       = {1'b0, guess_reg} + {1'b0, quo_reg};
    assign new_guess = sum[DW:1];

    assign s_axis_tready = (state_reg == psqrt_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = psqrt_pkg::TDATA_WIDTH'(root_reg);
    assign out_take      = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psqrt_pkg::ST_IDLE;
            steps_reg     <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        guess_reg  <= guess_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
        root_reg   <= root_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg && !out_take;
        n_next         = n_reg;
        guess_next     = guess_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        result_next    = result_reg;
        root_next      = root_reg;

        unique case (state_reg)
            psqrt_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    n_next       = in_value;
                    guess_next   = {1'b0, in_value[DW-1:1]};
                    rem_next     = '0;
                    quo_next     = in_value;
                    bit_cnt_next = psqrt_pkg::BIT_CNT_W'(DW);
                    steps_next   = '0;
                    if (echo)
                    begin
                        result_next = in_value;
                        state_next  = psqrt_pkg::ST_DONE;
                    end
                    else
                    begin
                        // initial guess n/2 is nonzero for n >= 2
                        state_next = psqrt_pkg::ST_DIV_A;
                    end
                end
            end

            psqrt_pkg::ST_DIV_A,
            psqrt_pkg::ST_DIV_B:
            begin
                rem_next     = q_bit ? diff[DW-1:0] : trial[DW-1:0];
                quo_next     = {quo_reg[DW-2:0], q_bit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == psqrt_pkg::BIT_CNT_W'(1))
                begin
                    state_next = (state_reg == psqrt_pkg::ST_DIV_A) ?
                                 psqrt_pkg::ST_TEST_A : psqrt_pkg::ST_TEST_B;
                end
            end

            psqrt_pkg::ST_TEST_A:
            begin
                rem_next     = '0;
                quo_next     = n_reg;
                bit_cnt_next = psqrt_pkg::BIT_CNT_W'(DW);
                guess_next   = new_guess;
                if (!ge_test || (new_guess == '0))
                begin
                    // guess already below the root: no exact square
                    result_next = '1;
                    state_next  = psqrt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = psqrt_pkg::ST_DIV_B;
                end
            end

            psqrt_pkg::ST_TEST_B:
            begin
                rem_next     = '0;
                quo_next     = n_reg;
                bit_cnt_next = psqrt_pkg::BIT_CNT_W'(DW);
                steps_next   = steps_reg + 1'b1;
                if (exact)
                begin
                    result_next = guess_reg;
                    state_next  = psqrt_pkg::ST_DONE;
                end
                else if (steps_reg == psqrt_pkg::STEP_W'(psqrt_pkg::MAX_STEPS - 1))
                begin
                    // step cap reached
                    steps_next  = '0;
                    result_next = '1;
                    state_next  = psqrt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = psqrt_pkg::ST_DIV_A;
                end
            end

            psqrt_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_axis_tready)
                begin
                    root_next      = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = psqrt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = psqrt_pkg::ST_IDLE;
            end
        endcase
    end

    // the divisor is never zero while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psqrt_pkg::ST_DIV_A || state_reg == psqrt_pkg::ST_DIV_B)
        |-> (guess_reg != '0))
        else $error("divider running with zero divisor");

    // a finished division leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psqrt_pkg::ST_TEST_A || state_reg == psqrt_pkg::ST_TEST_B)
        |-> (rem_reg < guess_reg))
        else $error("division remainder not below divisor");

    // the step counter stays within the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg < psqrt_pkg::STEP_W'(psqrt_pkg::MAX_STEPS))
        else $error("newton step counter out of range");

    // an accepted transaction always moves the block out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != psqrt_pkg::ST_IDLE))
        else $error("accepted transaction left the block idle");

endmodule
